@@ rtl/lh_pkg.sv @@
package lh_pkg;

   // Field widths fixed by the interface
   localparam int FIELD_W = 64;
   localparam int PCT_W   = 7;

   // Bucket store: one bucket per power of two
   localparam int              BKT_COUNT = 64;
   localparam int              BKT_W     = 6;
   localparam logic [BKT_W-1:0] BKT_LAST = 6'd63;

   // Largest legal percentile
   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

   // Request function codes
   localparam logic FUNC_OBSERVE = 1'b0;
   localparam logic FUNC_QUERY   = 1'b1;

   // Response status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

endpackage

@@ rtl/lh_req_if.sv @@
interface lh_req_if;
   import lh_pkg::*;

   logic                valid;
   logic                ready;
   logic                func;
   logic [FIELD_W-1:0]  sample_ns;
   logic [PCT_W-1:0]    percentile_pct;

   modport source (output valid, output func, output sample_ns, output percentile_pct,
                   input ready);
   modport sink   (input valid, input func, input sample_ns, input percentile_pct,
                   output ready);
endinterface

@@ rtl/lh_rsp_if.sv @@
interface lh_rsp_if;
   import lh_pkg::*;

   logic                valid;
   logic                ready;
   status_type          status;
   logic [FIELD_W-1:0]  percentile_bound;
   logic [FIELD_W-1:0]  samples_now;
   logic [FIELD_W-1:0]  sum_now;
   logic [FIELD_W-1:0]  max_now;
   logic                overflow_now;

   modport source (output valid, output status, output percentile_bound,
                   output samples_now, output sum_now, output max_now,
                   output overflow_now, input ready);
   modport sink   (input valid, input status, input percentile_bound,
                   input samples_now, input sum_now, input max_now,
                   input overflow_now, output ready);
endinterface

@@ rtl/lh_ram.sv @@
module lh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port; read data holds when idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/log2_latency_histogram.sv @@
// Latency histogram with power-of-two buckets.
// req_chan (valid/ready) carries one request: func observe files sample_ns
// into bucket floor(log2) (zero goes to bucket 0) and updates the sample
// count, time sum and maximum; func query returns the upper bound of the
// bucket that holds the requested percentile. rsp_chan returns exactly one
// response per request with status, bound and snapshots of count, sum, max
// and the sticky overflow flag. Counters saturate at all ones.
// Sequence: an observe reads its bucket from the bucket RAM, then in
// S_OBS writes it back and loads the response register. A query
// walks the RAM twice (total, then cumulative sums), one bucket per cycle;
// the second pass stops at the selected bucket. A percentile above 100
// goes straight to S_DONE. req_chan.ready rises in the same cycle that
// the response is presented.
// Reset: a clearing pass writes zero to all 64 buckets, with
// req_chan.ready low.
// The response sits in an output register; a new request is accepted
// while it waits, and the block holds in its final step until rsp_chan
// frees the register.
module log2_latency_histogram #(
   parameter int SAMPLE_WIDTH  = 64,
   parameter int COUNTER_WIDTH = 64
) (
   input  logic     clock,
   input  logic     reset,
   lh_req_if.sink   req_chan,
   lh_rsp_if.source rsp_chan
);
   import lh_pkg::*;

   localparam int SW = SAMPLE_WIDTH;
   localparam int CW = COUNTER_WIDTH;
   localparam int TW = COUNTER_WIDTH + PCT_W;
   localparam logic [FIELD_W-1:0] SAMPLE_ONES = FIELD_W'({SAMPLE_WIDTH{1'b1}});

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_OBS,
      S_SUM,
      S_RANK,
      S_WALK,
      S_DONE
   } state_type;

   // Saturating add; top bit flags saturation
   function automatic logic [CW:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[CW]) begin
         return {1'b1, {CW{1'b1}}};
      end
      return s;
   endfunction

   // Index of the highest set bit, 0 for zero
   function automatic logic [BKT_W-1:0] log2_idx(input logic [SW-1:0] v);
      logic [BKT_W-1:0] idx;
      idx = '0;
      for (int i = 1; i < SW; i++) begin
         if (v[i]) begin
            idx = BKT_W'(i);
         end
      end
      return idx;
   endfunction

   // Upper bound of a bucket, all ones of the sample width for the top one
   function automatic logic [FIELD_W-1:0] upper_of(input logic [BKT_W-1:0] idx);
      if ({1'b0, idx} >= (BKT_W+1)'(SW - 1)) begin
         return SAMPLE_ONES;
      end
      return ~({FIELD_W{1'b1}} << ((BKT_W+1)'(idx) + (BKT_W+1)'(1)));
   endfunction

   state_type          state_ff, state_in;
   logic [BKT_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [SW-1:0]      sample_ff, sample_in;
   logic [BKT_W-1:0]   bkt_ff, bkt_in;
   logic [PCT_W-1:0]   pct_ff, pct_in;
   logic [BKT_W:0]     rd_cnt_ff, rd_cnt_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [BKT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [CW-1:0]      acc_ff, acc_in;
   logic               acc_vld_ff, acc_vld_in;
   logic [BKT_W-1:0]   acc_idx_ff, acc_idx_in;
   logic [CW-1:0]      total_ff, total_in;
   logic [TW-1:0]      target_ff, target_in;
   status_type         status_ff, status_in;
   logic [FIELD_W-1:0] bound_ff, bound_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      sum_ff, sum_in;
   logic [SW-1:0]      max_ff, max_in;
   logic               ovf_ff, ovf_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0] rsp_bound_ff, rsp_bound_in;
   logic [FIELD_W-1:0] rsp_samples_ff, rsp_samples_in;
   logic [FIELD_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic [FIELD_W-1:0] rsp_max_ff, rsp_max_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               ram_we;
   logic [BKT_W-1:0]   ram_waddr;
   logic [CW-1:0]      ram_wdata;
   logic               ram_re;
   logic [BKT_W-1:0]   ram_raddr;
   logic [CW-1:0]      ram_rdata;

   logic [BKT_W-1:0]   req_bkt;
   logic               out_free;
   logic [CW:0]        bkt_new;
   logic [CW:0]        count_new;
   logic [CW:0]        sum_new;
   logic [CW:0]        acc_sum;
   logic [FIELD_W-1:0] sample_wide;
   logic [TW-1:0]      acc_x100;
   logic               walk_hit;

   lh_ram #(
      .WIDTH (CW),
      .DEPTH (BKT_COUNT)
   ) u_lh_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_bkt     = log2_idx(req_chan.sample_ns[SW-1:0]);
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign sample_wide = FIELD_W'(sample_ff);

   // Observe update terms
   assign bkt_new   = sat_add(ram_rdata, CW'(1));
   assign count_new = sat_add(count_ff, CW'(1));
   assign sum_new   = sat_add(sum_ff, sample_wide[CW-1:0]);

   // Walk terms: running sum, and cum*100 >= total*pct with cum at least 1
   assign acc_sum  = sat_add(acc_ff, ram_rdata);
   assign acc_x100 = (TW'(acc_ff) << 6) + (TW'(acc_ff) << 5) + (TW'(acc_ff) << 2);
   assign walk_hit = (acc_x100 >= target_ff) && (acc_ff != '0);

   assign req_chan.ready = (state_ff == S_IDLE);

   // Next-state logic
   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      sample_in      = sample_ff;
      bkt_in         = bkt_ff;
      pct_in         = pct_ff;
      rd_cnt_in      = rd_cnt_ff;
      rd_pend_in     = rd_pend_ff;
      rd_idx_in      = rd_idx_ff;
      acc_in         = acc_ff;
      acc_vld_in     = acc_vld_ff;
      acc_idx_in     = acc_idx_ff;
      total_in       = total_ff;
      target_in      = target_ff;
      status_in      = status_ff;
      bound_in       = bound_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      max_in         = max_ff;
      ovf_in         = ovf_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_bound_in   = rsp_bound_ff;
      rsp_samples_in = rsp_samples_ff;
      rsp_sum_in     = rsp_sum_ff;
      rsp_max_in     = rsp_max_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      ram_we         = 1'b0;
      ram_waddr      = bkt_ff;
      ram_wdata      = bkt_new[CW-1:0];
      ram_re         = 1'b0;
      ram_raddr      = rd_cnt_ff[BKT_W-1:0];

      // Shared sequential read engine for both query passes
      if (state_ff == S_SUM || state_ff == S_WALK) begin
         rd_pend_in = 1'b0;
         if (!rd_cnt_ff[BKT_W]) begin
            ram_re     = 1'b1;
            rd_cnt_in  = rd_cnt_ff + 1'b1;
            rd_pend_in = 1'b1;
            rd_idx_in  = rd_cnt_ff[BKT_W-1:0];
         end
         acc_vld_in = rd_pend_ff;
         if (rd_pend_ff) begin
            acc_in     = acc_sum[CW-1:0];
            acc_idx_in = rd_idx_ff;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            ram_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == BKT_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.func == FUNC_OBSERVE) begin
                  ram_re    = 1'b1;
                  ram_raddr = req_bkt;
                  sample_in = req_chan.sample_ns[SW-1:0];
                  bkt_in    = req_bkt;
                  state_in  = S_OBS;
               end else begin
                  pct_in = req_chan.percentile_pct;
                  if (req_chan.percentile_pct > PCT_MAX) begin
                     status_in = ST_RANGE;
                     bound_in  = '0;
                     state_in  = S_DONE;
                  end else begin
                     rd_cnt_in  = '0;
                     rd_pend_in = 1'b0;
                     acc_in     = '0;
                     acc_vld_in = 1'b0;
                     state_in   = S_SUM;
                  end
               end
            end
         end
         S_OBS: begin
            // Bucket write-back and scalar updates once the output is free
            if (out_free) begin
               ram_we         = 1'b1;
               count_in       = count_new[CW-1:0];
               sum_in         = sum_new[CW-1:0];
               max_in         = (sample_ff > max_ff) ? sample_ff : max_ff;
               ovf_in         = ovf_ff | bkt_new[CW] | count_new[CW] | sum_new[CW];
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_OK;
               rsp_bound_in   = '0;
               rsp_samples_in = FIELD_W'(count_new[CW-1:0]);
               rsp_sum_in     = FIELD_W'(sum_new[CW-1:0]);
               rsp_max_in     = FIELD_W'((sample_ff > max_ff) ? sample_ff : max_ff);
               rsp_ovf_in     = ovf_ff | bkt_new[CW] | count_new[CW] | sum_new[CW];
               state_in       = S_IDLE;
            end
         end
         S_SUM: begin
            if (rd_pend_ff && rd_idx_ff == BKT_LAST) begin
               total_in = acc_sum[CW-1:0];
               state_in = S_RANK;
            end
         end
         S_RANK: begin
            if (total_ff == '0) begin
               status_in = ST_EMPTY;
               bound_in  = '0;
               state_in  = S_DONE;
            end else begin
               target_in  = TW'(total_ff) * TW'(pct_ff);
               rd_cnt_in  = '0;
               rd_pend_in = 1'b0;
               acc_in     = '0;
               acc_vld_in = 1'b0;
               state_in   = S_WALK;
            end
         end
         S_WALK: begin
            if (acc_vld_ff && walk_hit) begin
               status_in = ST_OK;
               bound_in  = upper_of(acc_idx_ff);
               state_in  = S_DONE;
            end else if (acc_vld_ff && acc_idx_ff == BKT_LAST) begin
               status_in = ST_EMPTY;
               bound_in  = '0;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_bound_in   = bound_ff;
               rsp_samples_in = FIELD_W'(count_ff);
               rsp_sum_in     = FIELD_W'(sum_ff);
               rsp_max_in     = FIELD_W'(max_ff);
               rsp_ovf_in     = ovf_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rd_cnt_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         acc_vld_ff   <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
         max_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rd_cnt_ff    <= rd_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         acc_vld_ff   <= acc_vld_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         max_ff       <= max_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff      <= sample_in;
      bkt_ff         <= bkt_in;
      pct_ff         <= pct_in;
      rd_idx_ff      <= rd_idx_in;
      acc_ff         <= acc_in;
      acc_idx_ff     <= acc_idx_in;
      total_ff       <= total_in;
      target_ff      <= target_in;
      status_ff      <= status_in;
      bound_ff       <= bound_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_bound_ff   <= rsp_bound_in;
      rsp_samples_ff <= rsp_samples_in;
      rsp_sum_ff     <= rsp_sum_in;
      rsp_max_ff     <= rsp_max_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.percentile_bound = rsp_bound_ff;
   assign rsp_chan.samples_now      = rsp_samples_ff;
   assign rsp_chan.sum_now          = rsp_sum_ff;
   assign rsp_chan.max_now          = rsp_max_ff;
   assign rsp_chan.overflow_now     = rsp_ovf_ff;

endmodule

@@ rtl/lh_chk.sv @@
module lh_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input lh_pkg::status_type           rsp_status,
   input logic [lh_pkg::FIELD_W-1:0]   rsp_bound,
   input logic                         rsp_overflow
);
   import lh_pkg::*;

   logic seen_ovf_ff, seen_ovf_in;

   // Tracks whether any response has shown the overflow flag
   assign seen_ovf_in = seen_ovf_ff | (rsp_valid & rsp_overflow);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ovf_ff <= 1'b0;
      end else begin
         seen_ovf_ff <= seen_ovf_in;
      end
   end

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_bound))
      else $error("response changed while stalled");

   // Only an ok query carries a bound
   a_bound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_bound == '0)
      else $error("nonzero bound on a non-ok response");

   // Overflow flag is sticky across responses
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_ovf_ff |-> rsp_overflow)
      else $error("overflow flag dropped");

   // Clearing pass blocks requests right after reset
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request accepted during bucket clear");

endmodule

bind log2_latency_histogram lh_chk u_lh_chk (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_status   (rsp_chan.status),
   .rsp_bound    (rsp_chan.percentile_bound),
   .rsp_overflow (rsp_chan.overflow_now)
);
